// ===== rtl/ptvd_pkg.sv =====
// shared types and constants for the packet table varint decoder
package ptvd_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned OffsetW = 48;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutDataW = OffsetW + 2 * ValueW;

  // continuation flag and payload bits of one table byte
  localparam logic [ByteW-1:0] ContMask    = 8'h80;
  localparam logic [ByteW-1:0] PayloadMask = 8'h7f;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIXED_BYTES  = 2'd0,
    CFG_FIXED_FRAMES = 2'd1,
    CFG_PACKET_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_RESTART = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [ValueW-1:0]  frame_count;
    logic [ValueW-1:0]  data_size;
    logic [OffsetW-1:0] start_offset;
  } desc_t;

endpackage

// ===== rtl/packet_table_varint_decoder.sv =====
// packet table decoder: varint bytes in, packet descriptors out
// Usage:
// - slave stream carries one table byte per request: tdata = byte_value,
//   tuser = kind (0 table byte, 1 restart decoding, clears the decode state)
// - master stream carries one packet descriptor per request:
//   tdata = start_offset, data_size, frame_count (lowest bits first),
//   tlast = final packet of the table (packet number packet_count)
// - configuration port: cfg_we_i writes register cfg_idx_i
//   (0 fixed_packet_bytes, 1 fixed_packet_frames, 2 packet_count);
//   write only while no request is in flight
// - a descriptor is registered and appears in the cycle after the byte that ends it is accepted
// - throughput: one byte per cycle while s_axis_tready is high; the state update
//   and descriptor are formed by one shift-or and one 48-bit add in the accepting cycle
// - the output register is refilled in the same cycle it is drained, so
//   s_axis_tready only drops while a descriptor waits and m_axis_tready is low
// - reset clears the configuration registers, the decode state and the output valid
// - bytes after the last packet, and varint continuation bytes, give
//   no descriptor; in fully fixed mode every byte gives one
module packet_table_varint_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptvd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptvd_pkg::ValueW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ptvd_pkg::ByteW-1:0]    s_axis_tdata,   // byte_value
  input  logic                          s_axis_tuser,   // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ptvd_pkg::OutDataW-1:0] m_axis_tdata,   // start_offset, data_size, frame_count
  output logic                          m_axis_tlast    // last
);

  logic [ptvd_pkg::ValueW-1:0] fixed_bytes_q, fixed_frames_q, packet_count_q;

  logic [ptvd_pkg::ValueW-1:0]  acc_q, acc_d;
  logic                         rd_frames_q, rd_frames_d;
  logic [ptvd_pkg::ValueW-1:0]  pend_size_q, pend_size_d;
  logic [ptvd_pkg::OffsetW-1:0] offset_q, offset_d;
  logic [ptvd_pkg::ValueW-1:0]  done_q, done_d;

  logic                 out_valid_q, out_valid_d;
  ptvd_pkg::desc_t      desc_q, desc_d;
  logic                 last_q, last_d;

  logic                        in_acc;
  logic                        more;
  logic                        emit;
  logic [ptvd_pkg::ValueW-1:0] acc_next;
  logic [ptvd_pkg::ValueW-1:0] emit_size, emit_frames;
  logic [ptvd_pkg::ValueW-1:0] done_inc;
  logic                        bytes_fix, frames_fix;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign more          = |(s_axis_tdata & ptvd_pkg::ContMask);
  assign acc_next      = {acc_q[ptvd_pkg::ValueW-8:0],
                          s_axis_tdata[ptvd_pkg::ByteW-2:0] &
                          ptvd_pkg::PayloadMask[ptvd_pkg::ByteW-2:0]};
  assign bytes_fix     = fixed_bytes_q != '0;
  assign frames_fix    = fixed_frames_q != '0;
  assign done_inc      = done_q + ptvd_pkg::ValueW'(1);

  always_comb begin
    acc_d       = acc_q;
    rd_frames_d = rd_frames_q;
    pend_size_d = pend_size_q;
    offset_d    = offset_q;
    done_d      = done_q;
    emit        = 1'b0;
    emit_size   = fixed_bytes_q;
    emit_frames = fixed_frames_q;

    if (in_acc) begin
      if (s_axis_tuser == ptvd_pkg::KIND_RESTART) begin
        acc_d       = '0;
        rd_frames_d = 1'b0;
        pend_size_d = '0;
        offset_d    = '0;
        done_d      = '0;
      end else if (done_q < packet_count_q) begin
        if (bytes_fix && frames_fix) begin
          emit = 1'b1;
        end else if (more) begin
          acc_d = acc_next;
        end else if (bytes_fix) begin
          emit        = 1'b1;
          emit_frames = acc_next;
        end else if (frames_fix) begin
          emit      = 1'b1;
          emit_size = acc_next;
        end else if (!rd_frames_q) begin
          pend_size_d = acc_next;
          acc_d       = '0;
          rd_frames_d = 1'b1;
        end else begin
          emit        = 1'b1;
          emit_size   = pend_size_q;
          emit_frames = acc_next;
        end
      end
    end

    if (emit) begin
      acc_d       = '0;
      rd_frames_d = 1'b0;
      pend_size_d = '0;
      offset_d    = offset_q + ptvd_pkg::OffsetW'(emit_size);
      done_d      = done_inc;
    end
  end

  // output register, refilled while being drained
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    desc_d      = desc_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d         = 1'b1;
      desc_d.start_offset = offset_q;
      desc_d.data_size    = emit_size;
      desc_d.frame_count  = emit_frames;
      last_d              = done_inc == packet_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_bytes_q  <= '0;
      fixed_frames_q <= '0;
      packet_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptvd_pkg::CFG_FIXED_BYTES:  fixed_bytes_q  <= cfg_wdata_i;
        ptvd_pkg::CFG_FIXED_FRAMES: fixed_frames_q <= cfg_wdata_i;
        ptvd_pkg::CFG_PACKET_COUNT: packet_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      rd_frames_q <= 1'b0;
      pend_size_q <= '0;
      offset_q    <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      rd_frames_q <= rd_frames_d;
      pend_size_q <= pend_size_d;
      offset_q    <= offset_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = desc_q;
  assign m_axis_tlast  = last_q;

endmodule

// ===== rtl/ptvd_checker.sv =====
// port-level checks for the packet table decoder, bound to the top level
module ptvd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ptvd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // a waiting descriptor holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("descriptor changed while stalled");

  // input is only held off by a stalled descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a restart request never produces a descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ptvd_pkg::KIND_RESTART &&
    !(m_axis_tvalid && !m_axis_tready) |=> !m_axis_tvalid)
    else $error("descriptor after restart");

endmodule

bind packet_table_varint_decoder ptvd_checker u_ptvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
